### rtl/hsv_to_rgb_converter_unit_macros.svh
// Assertion macros for the HSV to RGB converter.
// Expects clk and rst_n in the scope of each use.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define HSVRGB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSVRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hsvrgb_pkg.sv
// Package for the HSV to RGB converter: widths, hue sector codes, tag type,
// and the exact divide-by-255 helper. No dependencies.
`default_nettype none

package hsvrgb_pkg;

  localparam int CH_W    = 8;
  localparam int FULL    = 255;
  localparam int FULL_SQ = FULL * FULL;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t           sector;
    logic [CH_W-1:0]   v;
  } hsvrgb_tag_t;

  // floor(x / 255) for x below 2^24 with a quotient below 2^16
  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [24:0] sum;
    logic [15:0] q;
    logic [24:0] rem;
    sum = {1'b0, x} + {9'b0, x[23:8]} + {17'b0, x[23:16]};
    q   = sum[23:8];
    rem = {1'b0, x} - ({1'b0, q, 8'b0} - {9'b0, q});
    if (rem >= 25'(FULL)) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### rtl/hsvrgb_levels.sv
// Level pipeline of the HSV to RGB converter: computes p, q and t from
// fraction, saturation and brightness over four register stages. Uses hsvrgb_pkg.
`default_nettype none

module hsvrgb_levels (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     s_valid,
  input  wire hsvrgb_pkg::hsvrgb_tag_t  s_tag,
  input  wire logic [7:0]               s_frac,
  input  wire logic [7:0]               s_sat,
  output logic                          m_valid,
  output hsvrgb_pkg::hsvrgb_tag_t       m_tag,
  output logic [7:0]                    m_p,
  output logic [7:0]                    m_q,
  output logic [7:0]                    m_t
);
  import hsvrgb_pkg::*;
  `include "hsv_to_rgb_converter_unit_macros.svh"

  logic [3:0]  vld_r;
  hsvrgb_tag_t tag2_r, tag3_r, tag4_r, tag5_r;
  logic [15:0] fs_r, gs_r, pv_r;
  logic [23:0] qprod_r, tprod_r;
  logic [7:0]  p3_r, p4_r, p5_r;
  logic [15:0] q4_r, t4_r;
  logic [7:0]  q5_r, t5_r;

  logic [15:0] fs_nxt, gs_nxt, pv_nxt;
  logic [15:0] qn, tn;
  logic [23:0] qprod_nxt, tprod_nxt;
  logic [15:0] p3_full, q4_nxt, t4_nxt, q5_full, t5_full;

  always_comb begin
    fs_nxt    = {8'b0, s_frac} * {8'b0, s_sat};
    gs_nxt    = (16'(FULL) - {8'b0, s_frac}) * {8'b0, s_sat};
    pv_nxt    = {8'b0, s_tag.v} * (16'(FULL) - {8'b0, s_sat});
    qn        = 16'(FULL_SQ) - fs_r;
    tn        = 16'(FULL_SQ) - gs_r;
    qprod_nxt = {16'b0, tag2_r.v} * {8'b0, qn};
    tprod_nxt = {16'b0, tag2_r.v} * {8'b0, tn};
    p3_full   = div255({8'b0, pv_r});
    q4_nxt    = div255(qprod_r);
    t4_nxt    = div255(tprod_r);
    q5_full   = div255({8'b0, q4_r});
    t5_full   = div255({8'b0, t4_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], s_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag2_r  <= s_tag;
    fs_r    <= fs_nxt;
    gs_r    <= gs_nxt;
    pv_r    <= pv_nxt;
    tag3_r  <= tag2_r;
    qprod_r <= qprod_nxt;
    tprod_r <= tprod_nxt;
    p3_r    <= p3_full[7:0];
    tag4_r  <= tag3_r;
    q4_r    <= q4_nxt;
    t4_r    <= t4_nxt;
    p4_r    <= p3_r;
    tag5_r  <= tag4_r;
    q5_r    <= q5_full[7:0];
    t5_r    <= t5_full[7:0];
    p5_r    <= p4_r;
  end

  assign m_valid = vld_r[3];
  assign m_tag   = tag5_r;
  assign m_p     = p5_r;
  assign m_q     = q5_r;
  assign m_t     = t5_r;

  `HSVRGB_ASSERT_IMP(a_lvl_below_v, m_valid,
    m_p <= m_tag.v && m_q <= m_tag.v && m_t <= m_tag.v, "level above brightness")
  `HSVRGB_ASSERT_IMP(a_lvl_above_p, m_valid,
    m_q >= m_p && m_t >= m_p, "ramp level below p")

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_converter_unit.sv
// Top level of the HSV to RGB converter: hue sector decode, level pipeline
// and channel select. Uses hsvrgb_pkg and hsvrgb_levels.
//
// Usage:
//   Input: drive in_hue, in_saturation and in_brightness with start high;
//   the item transfers at any rising edge where start is high and busy is
//   low. busy is always low, so one item can transfer every clock.
//   Output: out_valid strobes for one cycle with out_red, out_green and
//   out_blue; that cycle's closing edge is the transfer. The receiver
//   cannot stall the block, and none is needed.
// Pipeline: six register stages (input register, four level stages, output
//   register) lie between the transfer edge and the result strobe.
// Throughput: one item per clock, set by the fully pipelined datapath
//   (three 8x8 multiplies, two 8x16 multiplies, three divide-by-255
//   stages).
// Reset: synchronous, active low rst_n clears all valid bits; items in
//   flight are dropped and no result strobes until new items arrive.
`default_nettype none

module hsv_to_rgb_converter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_hue,
  input  wire logic [7:0] in_saturation,
  input  wire logic [7:0] in_brightness,
  output logic            out_valid,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue
);
  import hsvrgb_pkg::*;
  `include "hsv_to_rgb_converter_unit_macros.svh"

  logic        s1_valid_r;
  hsvrgb_tag_t s1_tag_r;
  logic [7:0]  s1_frac_r, s1_sat_r;
  logic        out_valid_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;

  logic [10:0] scaled;
  logic [10:0] base;
  sector_t     sector_nxt;
  logic [10:0] frac_full;
  logic        lv_valid;
  hsvrgb_tag_t lv_tag;
  logic [7:0]  lv_p, lv_q, lv_t;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;

  assign busy = 1'b0;

  always_comb begin
    scaled = {3'b0, in_hue} * 11'd6;
    if (scaled >= 11'(6 * FULL)) begin
      sector_nxt = SEC_RY;
      base       = 11'(6 * FULL);
    end else if (scaled >= 11'(5 * FULL)) begin
      sector_nxt = SEC_MR;
      base       = 11'(5 * FULL);
    end else if (scaled >= 11'(4 * FULL)) begin
      sector_nxt = SEC_BM;
      base       = 11'(4 * FULL);
    end else if (scaled >= 11'(3 * FULL)) begin
      sector_nxt = SEC_CB;
      base       = 11'(3 * FULL);
    end else if (scaled >= 11'(2 * FULL)) begin
      sector_nxt = SEC_GC;
      base       = 11'(2 * FULL);
    end else if (scaled >= 11'(FULL)) begin
      sector_nxt = SEC_YG;
      base       = 11'(FULL);
    end else begin
      sector_nxt = SEC_RY;
      base       = 11'd0;
    end
    frac_full = scaled - base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= start && !busy;
      out_valid_r <= lv_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r.sector <= sector_nxt;
    s1_tag_r.v      <= in_brightness;
    s1_frac_r       <= frac_full[7:0];
    s1_sat_r        <= in_saturation;
    out_red_r       <= red_nxt;
    out_green_r     <= green_nxt;
    out_blue_r      <= blue_nxt;
  end

  hsvrgb_levels u_levels (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s1_valid_r),
    .s_tag   (s1_tag_r),
    .s_frac  (s1_frac_r),
    .s_sat   (s1_sat_r),
    .m_valid (lv_valid),
    .m_tag   (lv_tag),
    .m_p     (lv_p),
    .m_q     (lv_q),
    .m_t     (lv_t)
  );

  always_comb begin
    case (lv_tag.sector)
      SEC_RY: begin
        red_nxt = lv_tag.v; green_nxt = lv_t;     blue_nxt = lv_p;
      end
      SEC_YG: begin
        red_nxt = lv_q;     green_nxt = lv_tag.v; blue_nxt = lv_p;
      end
      SEC_GC: begin
        red_nxt = lv_p;     green_nxt = lv_tag.v; blue_nxt = lv_t;
      end
      SEC_CB: begin
        red_nxt = lv_p;     green_nxt = lv_q;     blue_nxt = lv_tag.v;
      end
      SEC_BM: begin
        red_nxt = lv_t;     green_nxt = lv_p;     blue_nxt = lv_tag.v;
      end
      default: begin
        red_nxt = lv_tag.v; green_nxt = lv_p;     blue_nxt = lv_q;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  `HSVRGB_ASSERT_NEXT(a_capture, start && !busy,
    s1_valid_r && s1_tag_r.v == $past(in_brightness), "input transfer not captured")
  `HSVRGB_ASSERT_IMP(a_out_origin, out_valid, $past(start, 6), "result without transfer")
  `HSVRGB_ASSERT_IMP(a_black, out_valid && $past(in_brightness, 6) == 8'd0,
    out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0, "zero brightness not black")
  `HSVRGB_ASSERT_IMP(a_gray, out_valid && $past(in_saturation, 6) == 8'd0,
    out_red == out_green && out_green == out_blue, "zero saturation not gray")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for hsv_to_rgb_converter_unit: sector decode, p/q/t levels
// and channel table are checked per transfer. Needs hsvrgb_pkg and the unit's RTL.

module tb_top;
  import hsvrgb_pkg::*;

  localparam int NUM_SECTORS = 6;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    int unsigned idle_pct;
  } hsv_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [7:0] in_hue = '0;
  logic [7:0] in_saturation = '0;
  logic [7:0] in_brightness = '0;
  wire logic       busy;
  wire logic       out_valid;
  wire logic [7:0] out_red;
  wire logic [7:0] out_green;
  wire logic [7:0] out_blue;

  hsv_item_t hsv_pending_q[$];
  rgb_t      rgb_due_q[$];
  logic      took_item = 1'b0;
  int        hsv_queued = 0;
  int        hsv_taken = 0;
  int        fail_count = 0;

  hsv_to_rgb_converter_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rgb_t hsv_to_rgb(input logic [7:0] h, input logic [7:0] s,
                                      input logic [7:0] v);
    int unsigned hh, ss, vv, scaled, idx, frac, lvl_p, lvl_q, lvl_t;
    sector_t sec;
    rgb_t c;
    hh = h;
    ss = s;
    vv = v;
    scaled = hh * NUM_SECTORS;
    idx = scaled / FULL;
    frac = scaled - idx * FULL;
    // wrap the top of the hue circle back to the first sector
    if (idx >= NUM_SECTORS) begin
      idx = 0;
    end
    sec = sector_t'(idx[2:0]);
    lvl_p = (vv * (FULL - ss)) / FULL;
    lvl_q = (vv * (FULL_SQ - frac * ss)) / FULL_SQ;
    lvl_t = (vv * (FULL_SQ - (FULL - frac) * ss)) / FULL_SQ;
    case (sec)
      SEC_RY: begin
        c.red = vv[7:0];    c.green = lvl_t[7:0]; c.blue = lvl_p[7:0];
      end
      SEC_YG: begin
        c.red = lvl_q[7:0]; c.green = vv[7:0];    c.blue = lvl_p[7:0];
      end
      SEC_GC: begin
        c.red = lvl_p[7:0]; c.green = vv[7:0];    c.blue = lvl_t[7:0];
      end
      SEC_CB: begin
        c.red = lvl_p[7:0]; c.green = lvl_q[7:0]; c.blue = vv[7:0];
      end
      SEC_BM: begin
        c.red = lvl_t[7:0]; c.green = lvl_p[7:0]; c.blue = vv[7:0];
      end
      default: begin
        c.red = vv[7:0];    c.green = lvl_p[7:0]; c.blue = lvl_q[7:0];
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic add_hsv(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                         input int unsigned idle_pct);
    hsv_item_t it;
    it.hue = h;
    it.sat = s;
    it.val = v;
    it.idle_pct = idle_pct;
    hsv_pending_q.push_back(it);
    hsv_queued++;
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_hue();
    logic [7:0] edges[10] = '{8'd42, 8'd43, 8'd85, 8'd127, 8'd128,
                               8'd170, 8'd212, 8'd213, 8'd254, 8'd255};
    if ($urandom_range(5) == 0) begin
      return edges[$urandom_range(9)];
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic add_random_phase(input int count, input int unsigned idle_pct);
    for (int n = 0; n < count; n++) begin
      add_hsv(pick_hue(), pick_level(), pick_level(), idle_pct);
    end
  endtask

  // drive: advance to the next item once the current one has transferred
  always @(negedge clk) begin : drive
    hsv_item_t it;
    if (rst_n && (!start || took_item)) begin
      if (hsv_pending_q.size() != 0 &&
          $urandom_range(99) >= hsv_pending_q[0].idle_pct) begin
        it = hsv_pending_q.pop_front();
        start <= 1'b1;
        in_hue <= it.hue;
        in_saturation <= it.sat;
        in_brightness <= it.val;
      end else begin
        start <= 1'b0;
        in_hue <= 8'($urandom_range(255));
        in_saturation <= 8'($urandom_range(255));
        in_brightness <= 8'($urandom_range(255));
      end
    end
  end

  always @(posedge clk) begin : observe
    rgb_t exp_rgb;
    if (rst_n) begin
      if (out_valid) begin
        if (rgb_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                    out_red, out_green, out_blue));
        end else begin
          exp_rgb = rgb_due_q.pop_front();
          if (out_red !== exp_rgb.red) begin
            report_mismatch($sformatf("red got %0d exp %0d", out_red, exp_rgb.red));
          end
          if (out_green !== exp_rgb.green) begin
            report_mismatch($sformatf("green got %0d exp %0d", out_green, exp_rgb.green));
          end
          if (out_blue !== exp_rgb.blue) begin
            report_mismatch($sformatf("blue got %0d exp %0d", out_blue, exp_rgb.blue));
          end
        end
      end
      took_item <= start && !busy;
      if (start && !busy) begin
        rgb_due_q.push_back(hsv_to_rgb(in_hue, in_saturation, in_brightness));
        hsv_taken++;
      end
    end else begin
      took_item <= 1'b0;
    end
  end

  initial begin : stimulus
    int waited;
    // sector boundaries at full saturation and brightness, hue wrap at the top, then gray, black and mixed levels
    add_hsv(8'd0,   8'd255, 8'd255, 0);
    add_hsv(8'd42,  8'd255, 8'd255, 0);
    add_hsv(8'd43,  8'd255, 8'd255, 0);
    add_hsv(8'd85,  8'd255, 8'd255, 0);
    add_hsv(8'd128, 8'd255, 8'd255, 0);
    add_hsv(8'd170, 8'd255, 8'd255, 0);
    add_hsv(8'd213, 8'd255, 8'd255, 0);
    add_hsv(8'd254, 8'd255, 8'd255, 0);
    add_hsv(8'd255, 8'd255, 8'd255, 0);
    add_hsv(8'd255, 8'd128, 8'd200, 0);
    add_hsv(8'd0,   8'd0,   8'd255, 0);
    add_hsv(8'd100, 8'd0,   8'd0,   0);
    add_hsv(8'd255, 8'd255, 8'd0,   0);
    add_hsv(8'd0,   8'd0,   8'd0,   0);
    add_hsv(8'd200, 8'd128, 8'd255, 0);
    add_hsv(8'd37,  8'd255, 8'd200, 0);
    add_hsv(8'd255, 8'd1,   8'd254, 0);
    add_hsv(8'd128, 8'd255, 8'd1,   0);
    add_hsv(8'd64,  8'd170, 8'd85,  0);
    add_hsv(8'd150, 8'd85,  8'd170, 0);
    add_hsv(8'd230, 8'd254, 8'd255, 0);
    add_random_phase(190, 0);
    add_random_phase(190, 86);
    add_random_phase(180, 0);
    add_random_phase(190, 32);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (hsv_taken == hsv_queued);
    waited = 0;
    while (rgb_due_q.size() != 0 && waited < DRAIN_CYCLES) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (rgb_due_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", rgb_due_q.size()));
    end
    if (fail_count == 0) begin
      $display("hsv_to_rgb_converter_unit verification clean");
    end else begin
      $display("hsv_to_rgb_converter_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[%0t] timeout", $realtime);
    $display("hsv_to_rgb_converter_unit verification failed");
    $finish;
  end

endmodule
